// ----- rtl/motsl_pkg.sv -----
// Shared types, codes and constants for the median-of-two-sorted-lists block.
package motsl_pkg;

	// Default list depth
	localparam int MAX_LEN = 1024;

	// Field widths fixed by the interface
	localparam int DATA_W = 32;
	localparam int MED_W  = 33;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	// Edge values used outside the ends of a list
	localparam logic signed [DATA_W-1:0] EDGE_LOW  = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] EDGE_HIGH = 32'sh7fff_ffff;

	// Item kinds (code 3 means nothing and is dropped)
	typedef enum logic [KIND_W-1:0] {
		KIND_FIRST   = 2'd0,
		KIND_SECOND  = 2'd1,
		KIND_COMPUTE = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_PART = 2'd1,
		STATUS_EMPTY   = 2'd2
	} status_t;

	// Input word
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
	} item_t;

	// Output word
	typedef struct packed {
		logic signed [MED_W-1:0] median_twice;
		logic [STAT_W-1:0]       status;
	} result_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CALC,
		ST_RD_LEFT,
		ST_RD_RIGHT,
		ST_RD_WAIT,
		ST_DECIDE,
		ST_MERGE,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/median_of_two_sorted_lists.sv -----
// Top level: list loading and partition search for twice the median of two sorted lists.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------------------
//  item    | in        | item_valid / item_ready    | kind, value (motsl_pkg::item_t)
//  result  | out       | result_valid / result_ready| median_twice, status (result_t)
//
// An append word is written to its list RAM in the cycle it is taken.
// A compute word runs P probe steps, at most
// floor(log2(m+1)) + 1 with m the shorter length: each probe reads two entries
// of each list through the single read port of each list RAM, then compares.
// With both lists empty there is no probe: the sequencer goes from ST_SETUP to ST_DONE.
// Reset clears counts, sequencer and output valid; list contents are not cleared.
// A pending result does not block appends; a finished compute waits in ST_DONE
// until the output register is free.
module median_of_two_sorted_lists #(
	parameter int MAX_LEN = motsl_pkg::MAX_LEN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  motsl_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output motsl_pkg::result_t result
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SW = CW + 2;
	localparam int DW = motsl_pkg::DATA_W;
	localparam int MW = motsl_pkg::MED_W;
	localparam logic signed [SW-1:0] ONE  = SW'(1);
	localparam logic signed [SW-1:0] ZERO = '0;

	motsl_pkg::state_t state_q, state_d;

	logic [CW-1:0] first_count_q, second_count_q;
	logic          result_valid_q;
	motsl_pkg::result_t result_q;

	logic signed [SW-1:0] short_len_q, long_len_q, half_q, low_q, high_q, px_q, py_q;
	logic                 swap_q, odd_q;
	logic signed [DW-1:0] lx_q, rx_q, ly_q, ry_q;
	logic signed [MW-1:0] res_median_q;
	logic [motsl_pkg::STAT_W-1:0] res_status_q;

	logic                 accept, first_we, second_we, out_free, fit;
	logic signed [SW-1:0] short_idx, long_idx, px_next, total;
	logic [AW-1:0]        first_raddr, second_raddr;
	logic [DW-1:0]        first_rdata, second_rdata;
	logic signed [DW-1:0] short_rd, long_rd, lmax, rmin;

	// List memories
	motsl_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_first_ram (
		.clk   (clk),
		.we    (first_we),
		.waddr (first_count_q[AW-1:0]),
		.wdata (item.value),
		.raddr (first_raddr),
		.rdata (first_rdata)
	);

	motsl_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_second_ram (
		.clk   (clk),
		.we    (second_we),
		.waddr (second_count_q[AW-1:0]),
		.wdata (item.value),
		.raddr (second_raddr),
		.rdata (second_rdata)
	);

	// Handshake and append decode
	assign accept    = item_valid && item_ready;
	assign first_we  = accept && (item.kind == motsl_pkg::KIND_FIRST)
		&& (first_count_q < CW'(MAX_LEN));
	assign second_we = accept && (item.kind == motsl_pkg::KIND_SECOND)
		&& (second_count_q < CW'(MAX_LEN));
	assign out_free  = !result_valid_q || result_ready;

	// Shared compare unit and merge terms
	assign short_rd = swap_q ? $signed(second_rdata) : $signed(first_rdata);
	assign long_rd  = swap_q ? $signed(first_rdata) : $signed(second_rdata);
	assign fit      = (lx_q <= ry_q) && (ly_q <= rx_q);
	assign lmax     = (lx_q > ly_q) ? lx_q : ly_q;
	assign rmin     = (rx_q < ry_q) ? rx_q : ry_q;
	assign px_next  = low_q + ((high_q - low_q) >>> 1);
	assign total    = short_len_q + long_len_q;

	// Next state and RAM read addresses
	always_comb begin
		state_d    = state_q;
		item_ready = (state_q == motsl_pkg::ST_IDLE);
		short_idx  = px_q;
		long_idx   = py_q;
		unique case (state_q)
			motsl_pkg::ST_IDLE: begin
				if (item_valid && (item.kind == motsl_pkg::KIND_COMPUTE)) begin
					state_d = motsl_pkg::ST_SETUP;
				end
			end
			motsl_pkg::ST_SETUP: begin
				state_d = (total == ZERO) ? motsl_pkg::ST_DONE : motsl_pkg::ST_CALC;
			end
			motsl_pkg::ST_CALC: begin
				state_d = (low_q > high_q) ? motsl_pkg::ST_DONE : motsl_pkg::ST_RD_LEFT;
			end
			motsl_pkg::ST_RD_LEFT: begin
				short_idx = px_q - ONE;
				long_idx  = py_q - ONE;
				state_d   = motsl_pkg::ST_RD_RIGHT;
			end
			motsl_pkg::ST_RD_RIGHT: begin
				state_d = motsl_pkg::ST_RD_WAIT;
			end
			motsl_pkg::ST_RD_WAIT: begin
				state_d = motsl_pkg::ST_DECIDE;
			end
			motsl_pkg::ST_DECIDE: begin
				state_d = fit ? motsl_pkg::ST_MERGE : motsl_pkg::ST_CALC;
			end
			motsl_pkg::ST_MERGE: begin
				state_d = motsl_pkg::ST_DONE;
			end
			motsl_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = motsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = motsl_pkg::ST_IDLE;
			end
		endcase
		first_raddr  = swap_q ? long_idx[AW-1:0] : short_idx[AW-1:0];
		second_raddr = swap_q ? short_idx[AW-1:0] : long_idx[AW-1:0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= motsl_pkg::ST_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (item.kind == motsl_pkg::KIND_COMPUTE)) begin
				first_count_q  <= '0;
				second_count_q <= '0;
			end else begin
				if (first_we) begin
					first_count_q <= first_count_q + CW'(1);
				end
				if (second_we) begin
					second_count_q <= second_count_q + CW'(1);
				end
			end
			if ((state_q == motsl_pkg::ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			motsl_pkg::ST_IDLE: begin
				if (accept && (item.kind == motsl_pkg::KIND_COMPUTE)) begin
					swap_q <= first_count_q > second_count_q;
					if (first_count_q > second_count_q) begin
						short_len_q <= $signed({2'b00, second_count_q});
						long_len_q  <= $signed({2'b00, first_count_q});
					end else begin
						short_len_q <= $signed({2'b00, first_count_q});
						long_len_q  <= $signed({2'b00, second_count_q});
					end
				end
			end
			motsl_pkg::ST_SETUP: begin
				half_q       <= (total + ONE) >>> 1;
				odd_q        <= total[0];
				low_q        <= ZERO;
				high_q       <= short_len_q;
				res_median_q <= '0;
				res_status_q <= (total == ZERO) ? motsl_pkg::STATUS_EMPTY
					: motsl_pkg::STATUS_NO_PART;
			end
			motsl_pkg::ST_CALC: begin
				px_q <= px_next;
				py_q <= half_q - px_next;
			end
			motsl_pkg::ST_RD_RIGHT: begin
				// left neighbors come back from the previous read
				lx_q <= ((px_q >= ONE) && (px_q <= short_len_q)) ? short_rd
					: motsl_pkg::EDGE_LOW;
				ly_q <= ((py_q >= ONE) && (py_q <= long_len_q)) ? long_rd
					: motsl_pkg::EDGE_LOW;
			end
			motsl_pkg::ST_RD_WAIT: begin
				rx_q <= ((px_q >= ZERO) && (px_q < short_len_q)) ? short_rd
					: motsl_pkg::EDGE_HIGH;
				ry_q <= ((py_q >= ZERO) && (py_q < long_len_q)) ? long_rd
					: motsl_pkg::EDGE_HIGH;
			end
			motsl_pkg::ST_DECIDE: begin
				if (!fit) begin
					if (lx_q > ry_q) begin
						high_q <= px_q - ONE;
					end else begin
						low_q <= px_q + ONE;
					end
				end
			end
			motsl_pkg::ST_MERGE: begin
				res_median_q <= odd_q ? $signed({lmax, 1'b0})
					: $signed({lmax[DW-1], lmax}) + $signed({rmin[DW-1], rmin});
				res_status_q <= motsl_pkg::STATUS_OK;
			end
			motsl_pkg::ST_DONE: begin
				if (out_free) begin
					result_q.median_twice <= res_median_q;
					result_q.status       <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/motsl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module motsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/motsl_checker.sv -----
// Port-level checker for the median-of-two-sorted-lists block, with its bind.
module motsl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input motsl_pkg::item_t   item,
	input logic               result_valid,
	input logic               result_ready,
	input motsl_pkg::result_t result
);

	// A stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Error statuses carry a zero median
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((result.status == motsl_pkg::STATUS_NO_PART)
			|| (result.status == motsl_pkg::STATUS_EMPTY))
		|-> (result.median_twice == '0))
		else $error("nonzero median with error status");

	// The search occupies the block after a compute word
	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.kind == motsl_pkg::KIND_COMPUTE)
		|=> !item_ready)
		else $error("ready right after a compute word");

	// A new result never follows directly on an accepted word
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_valid && item_ready))
		else $error("result appeared one cycle after an accepted word");

endmodule

bind median_of_two_sorted_lists motsl_checker u_motsl_checker (.*);
